@@ hdl/emfd_pkg.sv @@
`default_nettype none

package emfd_pkg;

  // Field widths
  localparam int YEAR_W   = 14;
  localparam int MON_W    = 3;
  localparam int CMON_W   = 2;
  localparam int DOM_W    = 5;

  // Pipeline depth
  localparam int NUM_STAGES = 7;

  // Reciprocal multipliers: x / D == (x * RECIP_D) >> SHIFT_D over the value range used
  localparam int RECIP_100 = 5243;
  localparam int SHIFT_100 = 19;
  localparam int RECIP_19  = 27595;
  localparam int SHIFT_19  = 19;
  localparam int RECIP_25  = 41;
  localparam int SHIFT_25  = 10;
  localparam int RECIP_3   = 171;
  localparam int SHIFT_3   = 9;
  localparam int RECIP_30  = 2185;
  localparam int SHIFT_30  = 16;
  localparam int RECIP_7   = 147;
  localparam int SHIFT_7   = 10;

  // Computus constants
  localparam int GOLDEN_MOD   = 19;
  localparam int CENT_DIV     = 100;
  localparam int EPACT_MOD    = 30;
  localparam int EPACT_OFFS   = 15;
  localparam int WEEK_OFFS    = 32;
  localparam int WEEK_LEN     = 7;
  localparam int LATE_LIMIT   = 451;
  // Easter day counted from the last day of February (March 1 is day 1)
  localparam int MARCH_OFFS   = 22;

  // Month numbers
  localparam int MON_FEB = 2;
  localparam int MON_MAR = 3;
  localparam int MON_APR = 4;
  localparam int MON_MAY = 5;
  localparam int MON_JUN = 6;

  // Cumulative day counts from the end of February
  localparam int END_MAR = 31;
  localparam int END_APR = 61;
  localparam int END_MAY = 92;

  // Feast offsets from Easter
  localparam int OFFS_FRIDAY    = 2;
  localparam int OFFS_CARNIVAL  = 49;
  localparam int OFFS_CARN_END  = 47;
  localparam int OFFS_ASCENSION = 39;
  localparam int OFFS_WHITSUN   = 49;

  // Easter bounds
  localparam int EASTER_FIRST_MAR = 22;
  localparam int EASTER_LAST_APR  = 25;

endpackage

`default_nettype wire

@@ hdl/easter_movable_feast_dates.sv @@
`default_nettype none

// Easter and movable feast date pipeline.
//
// Input channel: year with in_valid / in_ready. A beat is taken at a rising
// edge with both high. Output channel: the twelve month / day-of-month fields
// with out_valid / out_ready, taken the same way.
//
// The edge that takes the year loads the first of seven register stages, and
// out_valid is the valid bit of the last. Throughput is one year per cycle
// while out_ready is high: every stage registers its data with a valid bit,
// and each stage loads whenever it is empty or the stage after it moves.
// Divisions by 100, 19, 25, 3, 30 and 7 are reciprocal multiplies with a
// shift: 100 and 19 in stage 1, then one per stage through stage 5. Stage 6
// applies the late correction and stage 7 splits each feast into month and day.
//
// Reset clears all valid bits; data registers are not reset. When the receiver
// holds out_ready low, the last stage holds its beat and the stages behind it
// fill up, so bubbles are squeezed out before in_ready drops. No beat is lost
// or repeated. Any 14-bit year is accepted and treated as proleptic Gregorian.
module easter_movable_feast_dates
  import emfd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [YEAR_W-1:0]   year,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [MON_W-1:0]         easter_mon,
  output logic [DOM_W-1:0]         easter_dom,
  output logic [MON_W-1:0]         friday_month,
  output logic [DOM_W-1:0]         friday_dom,
  output logic [CMON_W-1:0]        carnival_mon,
  output logic [DOM_W-1:0]         carnival_dom,
  output logic [CMON_W-1:0]        carnival_end_month,
  output logic [DOM_W-1:0]         carnival_end_dom,
  output logic [MON_W-1:0]         ascension_mon,
  output logic [DOM_W-1:0]         ascension_dom,
  output logic [MON_W-1:0]         whitsun_month,
  output logic [DOM_W-1:0]         whitsun_dom
);

  localparam int LAST = NUM_STAGES - 1;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] rdy;

  // Ready chain: a stage may load when it is empty or its beat moves on.
  always_comb begin
    rdy[LAST] = !vld[LAST] || out_ready;
    for (int s = LAST - 1; s >= 0; s--) begin
      rdy[s] = !vld[s] || rdy[s+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (rdy[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: century and golden-number quotients by reciprocal multiply.
  // ---------------------------------------------------------------------------
  logic [26:0] p100;
  logic [28:0] p19;
  logic [YEAR_W-1:0] s1_y;
  logic [7:0]        s1_b;
  logic [9:0]        s1_q19;

  assign p100 = 27'(year) * 27'(RECIP_100);
  assign p19  = 29'(year) * 29'(RECIP_19);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_y   <= year;
      s1_b   <= 8'(p100 >> SHIFT_100);
      s1_q19 <= 10'(p19 >> SHIFT_19);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: remainders, century split, leap flag, f = (b + 8) / 25.
  // ---------------------------------------------------------------------------
  logic [YEAR_W-1:0] m19;
  logic [YEAR_W-1:0] m100;
  logic [4:0]        a2;
  logic [6:0]        c2;
  logic [7:0]        b8;
  logic [13:0]       fprod;

  assign m19   = 14'(s1_q19) * 14'(GOLDEN_MOD);
  assign m100  = 14'(s1_b) * 14'(CENT_DIV);
  assign a2    = 5'(s1_y - m19);
  assign c2    = 7'(s1_y - m100);
  assign b8    = s1_b + 8'd8;
  assign fprod = 14'(b8) * 14'(RECIP_25);

  logic [4:0] s2_a;
  logic [7:0] s2_b;
  logic [5:0] s2_d;
  logic [1:0] s2_e;
  logic [2:0] s2_f;
  logic [4:0] s2_i;
  logic [1:0] s2_k;
  logic       s2_leap;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_a    <= a2;
      s2_b    <= s1_b;
      s2_d    <= s1_b[7:2];
      s2_e    <= s1_b[1:0];
      s2_f    <= 3'(fprod >> SHIFT_25);
      s2_i    <= c2[6:2];
      s2_k    <= c2[1:0];
      // Century years are leap only when the century divides by four.
      s2_leap <= (c2 == 7'd0) ? (s1_b[1:0] == 2'd0) : (c2[1:0] == 2'd0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: g = (b - f + 1) / 3, partial sums for the epact and weekday terms.
  // ---------------------------------------------------------------------------
  logic [7:0]  gnum;
  logic [15:0] gprod;
  logic [9:0]  hpart3;
  logic [6:0]  lpart3;

  assign gnum   = s2_b - 8'(s2_f) + 8'd1;
  assign gprod  = 16'(gnum) * 16'(RECIP_3);
  assign hpart3 = 10'(10'(GOLDEN_MOD) * 10'(s2_a)) + 10'(s2_b) - 10'(s2_d)
                  + 10'(EPACT_OFFS);
  assign lpart3 = 7'(WEEK_OFFS) + 7'({s2_e, 1'b0}) + 7'({s2_i, 1'b0}) - 7'(s2_k);

  logic [4:0] s3_a;
  logic [9:0] s3_hpart;
  logic [5:0] s3_g;
  logic [6:0] s3_lpart;
  logic       s3_leap;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_a     <= s2_a;
      s3_hpart <= hpart3;
      s3_g     <= 6'(gprod >> SHIFT_3);
      s3_lpart <= lpart3;
      s3_leap  <= s2_leap;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: epact h = (19a + b - d - g + 15) mod 30.
  // ---------------------------------------------------------------------------
  logic [9:0]  hv;
  logic [25:0] hprod;
  logic [4:0]  hq;
  logic [4:0]  h4;

  assign hv    = s3_hpart - 10'(s3_g);
  assign hprod = 26'(hv) * 26'(RECIP_30);
  assign hq    = 5'(hprod >> SHIFT_30);
  assign h4    = 5'(hv - 10'(10'(hq) * 10'(EPACT_MOD)));

  logic [4:0] s4_a;
  logic [4:0] s4_h;
  logic [6:0] s4_lpart;
  logic       s4_leap;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_a     <= s3_a;
      s4_h     <= h4;
      s4_lpart <= s3_lpart;
      s4_leap  <= s3_leap;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: weekday term l = (32 + 2e + 2i - h - k) mod 7.
  // ---------------------------------------------------------------------------
  logic [6:0]  lv;
  logic [14:0] lprod;
  logic [3:0]  lq;
  logic [2:0]  l5;

  assign lv    = s4_lpart - 7'(s4_h);
  assign lprod = 15'(lv) * 15'(RECIP_7);
  assign lq    = 4'(lprod >> SHIFT_7);
  assign l5    = 3'(lv - 7'(7'(lq) * 7'(WEEK_LEN)));

  logic [4:0] s5_a;
  logic [4:0] s5_h;
  logic [2:0] s5_l;
  logic       s5_leap;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s5_a    <= s4_a;
      s5_h    <= s4_h;
      s5_l    <= l5;
      s5_leap <= s4_leap;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: late-correction flag and Easter as a day count from March 1 = 1.
  // ---------------------------------------------------------------------------
  logic [8:0] mv;
  logic       late;
  logic [6:0] tsum;

  assign mv   = 9'(s5_a) + 9'(9'd11 * 9'(s5_h)) + 9'(9'd22 * 9'(s5_l));
  assign late = (mv >= 9'(LATE_LIMIT));
  assign tsum = 7'(s5_h) + 7'(s5_l) + 7'(MARCH_OFFS) - (late ? 7'(WEEK_LEN) : 7'd0);

  logic [5:0] s6_t;
  logic       s6_leap;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s6_t    <= 6'(tsum);
      s6_leap <= s5_leap;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: convert each feast's day count to month and day; output register.
  // ---------------------------------------------------------------------------
  logic [5:0] tf;
  logic [6:0] tasc;
  logic [6:0] twhit;
  logic [5:0] feb_len;

  assign tf      = s6_t - 6'(OFFS_FRIDAY);
  assign tasc    = 7'(s6_t) + 7'(OFFS_ASCENSION);
  assign twhit   = 7'(s6_t) + 7'(OFFS_WHITSUN);
  assign feb_len = s6_leap ? 6'd29 : 6'd28;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      if (s6_t <= 6'(END_MAR)) begin
        easter_mon <= 3'(MON_MAR);
        easter_dom <= 5'(s6_t);
      end else begin
        easter_mon <= 3'(MON_APR);
        easter_dom <= 5'(s6_t - 6'(END_MAR));
      end

      if (tf <= 6'(END_MAR)) begin
        friday_month <= 3'(MON_MAR);
        friday_dom   <= 5'(tf);
      end else begin
        friday_month <= 3'(MON_APR);
        friday_dom   <= 5'(tf - 6'(END_MAR));
      end

      // Falls back into February when the count drops to zero or below.
      if (s6_t > 6'(OFFS_CARNIVAL)) begin
        carnival_mon <= 2'(MON_MAR);
        carnival_dom <= 5'(s6_t - 6'(OFFS_CARNIVAL));
      end else begin
        carnival_mon <= 2'(MON_FEB);
        carnival_dom <= 5'(s6_t + feb_len - 6'(OFFS_CARNIVAL));
      end

      if (s6_t > 6'(OFFS_CARN_END)) begin
        carnival_end_month <= 2'(MON_MAR);
        carnival_end_dom   <= 5'(s6_t - 6'(OFFS_CARN_END));
      end else begin
        carnival_end_month <= 2'(MON_FEB);
        carnival_end_dom   <= 5'(s6_t + feb_len - 6'(OFFS_CARN_END));
      end

      priority if (tasc <= 7'(END_APR)) begin
        ascension_mon <= 3'(MON_APR);
        ascension_dom <= 5'(tasc - 7'(END_MAR));
      end else if (tasc <= 7'(END_MAY)) begin
        ascension_mon <= 3'(MON_MAY);
        ascension_dom <= 5'(tasc - 7'(END_APR));
      end else begin
        ascension_mon <= 3'(MON_JUN);
        ascension_dom <= 5'(tasc - 7'(END_MAY));
      end

      if (twhit <= 7'(END_MAY)) begin
        whitsun_month <= 3'(MON_MAY);
        whitsun_dom   <= 5'(twhit - 7'(END_APR));
      end else begin
        whitsun_month <= 3'(MON_JUN);
        whitsun_dom   <= 5'(twhit - 7'(END_MAY));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // An empty output register frees the whole pipeline.
  a_ready_when_drained: assert property (
    @(posedge clk) disable iff (rst) !out_valid |-> in_ready
  ) else $error("in_ready low with empty output register");

  // Easter day count stays within March 22 .. April 25.
  a_easter_count_range: assert property (
    @(posedge clk) disable iff (rst)
    vld[5] |-> (s6_t >= 6'(MARCH_OFFS)) && (s6_t <= 6'(END_MAR + EASTER_LAST_APR))
  ) else $error("Easter day count out of range");

  a_easter_date_range: assert property (
    @(posedge clk) disable iff (rst)
    out_valid |-> ((easter_mon == 3'(MON_MAR)) && (easter_dom >= 5'(EASTER_FIRST_MAR)))
               || ((easter_mon == 3'(MON_APR)) && (easter_dom <= 5'(EASTER_LAST_APR)))
  ) else $error("Easter date out of range");

  // A stalled last stage keeps its beat; the stage behind it must not drop its own.
  a_stall_keeps_beats: assert property (
    @(posedge clk) disable iff (rst)
    (vld[LAST] && !out_ready && vld[LAST-1]) |=> (vld[LAST] && vld[LAST-1])
  ) else $error("beat lost during stall");

endmodule

`default_nettype wire
